// ===== sv/four_level_page_table_walker_defines.svh =====
// Assertion macros used by the page table walker module.
`ifndef FOUR_LEVEL_PAGE_TABLE_WALKER_DEFINES_SVH
`define FOUR_LEVEL_PAGE_TABLE_WALKER_DEFINES_SVH
// Assert that a condition implies a consequence in the same cycle.
`define FLPT_ASSERT_IMP(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);
// Assert that a condition implies a consequence in the next cycle.
`define FLPT_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);
`endif

// ===== sv/flptw_pkg.sv =====
// Shared types and constants of the page table walker.
package flptw_pkg;
  localparam logic [1:0] CMD_TRANSLATE = 2'd0;
  localparam logic [1:0] CMD_MAP       = 2'd1;
  localparam logic [1:0] CMD_UNMAP     = 2'd2;
  localparam logic [1:0] CMD_CREATE    = 2'd3;

  localparam logic [1:0] ST_OK       = 2'd0;
  localparam logic [1:0] ST_BAD_ADDR = 2'd1;
  localparam logic [1:0] ST_NO_POOL  = 2'd2;
  localparam logic [1:0] ST_UNMAPPED = 2'd3;

  localparam logic [63:0] DESC_ADDR_MASK = 64'h0000_FFFF_FFFF_F000;
  localparam logic [63:0] KERNEL_VA_BASE = 64'hFFFF_0000_0000_0000;
  localparam logic [63:0] D_VALID = 64'd1;
  localparam logic [63:0] D_TABLE = 64'd2;
  localparam logic [63:0] D_AF = 64'd1 << 10;
  localparam logic [63:0] D_SH_IS = 64'd3 << 8;
  localparam logic [63:0] D_ATTR_NORMAL = 64'd4 << 2;
  localparam logic [63:0] D_PXN = 64'd1 << 53;
  localparam logic [63:0] D_UXN = 64'd1 << 54;
  localparam int IDX_W = 9;

  typedef struct packed {
    logic [1:0]  cmd;
    logic [47:0] root_addr;
    logic [63:0] va;
    logic [47:0] pa;
    logic [63:0] flags;
  } req_t;

  typedef struct packed {
    logic [1:0]  status;
    logic [47:0] phys_addr;
    logic        tlb_invalidate;
    logic [51:0] tlb_page;
  } rsp_t;
endpackage

// ===== sv/flptw_if.sv =====
// Valid/ready channel interfaces for requests, responses and configuration.
interface flptw_req_if;
  logic valid;
  logic ready;
  logic [1:0]  cmd;
  logic [47:0] root_addr;
  logic [63:0] va;
  logic [47:0] pa;
  logic [63:0] flags;
  modport source (output valid, cmd, root_addr, va, pa, flags, input ready);
  modport sink (input valid, cmd, root_addr, va, pa, flags, output ready);
endinterface

interface flptw_rsp_if;
  logic valid;
  logic ready;
  logic [1:0]  status;
  logic [47:0] phys_addr;
  logic        tlb_invalidate;
  logic [51:0] tlb_page;
  modport source (output valid, status, phys_addr, tlb_invalidate, tlb_page, input ready);
  modport sink (input valid, status, phys_addr, tlb_invalidate, tlb_page, output ready);
endinterface

interface flptw_cfg_if;
  logic valid;
  logic ready;
  logic [47:0] data;
  modport source (output valid, data, input ready);
  modport sink (input valid, data, output ready);
endinterface

// ===== sv/four_level_page_table_walker.sv =====
// Four-level page table walker: translate, map, unmap and create root tables.
// One command is processed at a time. A walk takes one to four dependent table
// reads, each through the registered-read table memory. An unmap adds a
// descriptor write. Each newly allocated table is cleared one entry per cycle,
// all 512 entries, both for create and for each table that a map builds. The
// memory port is shared by walk reads, descriptor writes and clearing.
module four_level_page_table_walker #(
  parameter int POOL_TABLES = 16
) (
  input logic clk,
  input logic rst,
  flptw_cfg_if.sink cfg,
  flptw_req_if.sink req,
  flptw_rsp_if.source rsp
);
`include "four_level_page_table_walker_defines.svh"
  localparam int TW = (POOL_TABLES > 1) ? $clog2(POOL_TABLES) : 1;
  localparam int CW = $clog2(POOL_TABLES + 1);
  localparam int AW = TW + flptw_pkg::IDX_W;

  typedef enum logic [6:0] {
    S_IDLE  = 7'b0000001,
    S_CHECK = 7'b0000010,
    S_READ  = 7'b0000100,
    S_EVAL  = 7'b0001000,
    S_CLEAR = 7'b0010000,
    S_WRITE = 7'b0100000,
    S_DONE  = 7'b1000000
  } state_t;

  state_t state;
  flptw_pkg::req_t cur;
  flptw_pkg::rsp_t res;
  logic [47:0] pool_base;
  logic [CW-1:0] next_free;
  logic [TW-1:0] tbl;
  logic [1:0] lv;
  logic [flptw_pkg::IDX_W-1:0] clr_idx;
  logic [flptw_pkg::IDX_W-1:0] slot_idx;
  logic [TW-1:0] slot_tbl;
  logic [TW-1:0] new_tbl;
  logic link_pending;
  logic [63:0] wr_val;
  logic create_mode;

  logic mem_we;
  logic [AW-1:0] mem_addr;
  logic [63:0] mem_wdata;
  logic [63:0] mem_rdata;

  flptw_mem #(.AW(AW)) u_mem (
    .clk(clk), .we(mem_we), .addr(mem_addr), .wdata(mem_wdata), .rdata(mem_rdata)
  );

  // Address checks against the pool
  function automatic logic [47:0] tbl_addr(input logic [47:0] base, input logic [CW-1:0] n);
    tbl_addr = {base[47:12], 12'd0} + {{(36 - CW){1'b0}}, n, 12'd0};
  endfunction

  logic [47:0] chk_addr;
  logic [47:0] chk_off;
  logic chk_ok;
  logic [TW-1:0] chk_tbl;
  always_comb begin
    chk_off = chk_addr - {pool_base[47:12], 12'd0};
    chk_ok = (chk_off[11:0] == 12'd0) && ({12'd0, chk_off[47:12]} < {{(48 - CW){1'b0}}, next_free});
    chk_tbl = chk_off[12 +: TW];
  end

  logic [flptw_pkg::IDX_W-1:0] cur_idx;
  logic [63:0] vpage;
  always_comb begin
    vpage = (cur.cmd == flptw_pkg::CMD_MAP) ? {cur.va[63:12], 12'd0} : cur.va;
    unique case (lv)
      2'd0: cur_idx = vpage[47:39];
      2'd1: cur_idx = vpage[38:30];
      2'd2: cur_idx = vpage[29:21];
      default: cur_idx = vpage[20:12];
    endcase
  end

  logic e_valid, e_table;
  assign e_valid = mem_rdata[0];
  assign e_table = mem_rdata[1];

  always_comb begin
    chk_addr = (state == S_CHECK) ? cur.root_addr : mem_rdata[47:0] & 48'hFFFF_FFFF_F000;
  end

  logic [63:0] page_desc;
  always_comb begin
    page_desc = ({16'd0, cur.pa} & flptw_pkg::DESC_ADDR_MASK) | flptw_pkg::D_VALID |
                flptw_pkg::D_TABLE | flptw_pkg::D_AF | flptw_pkg::D_SH_IS |
                flptw_pkg::D_ATTR_NORMAL | cur.flags;
    if (vpage >= flptw_pkg::KERNEL_VA_BASE) begin
      page_desc = page_desc | flptw_pkg::D_UXN | flptw_pkg::D_PXN;
    end
  end

  // Drive the memory port
  always_comb begin
    mem_we = 1'b0;
    mem_addr = {tbl, cur_idx};
    mem_wdata = wr_val;
    if (state == S_CLEAR) begin
      mem_we = 1'b1;
      mem_addr = {new_tbl, clr_idx};
      mem_wdata = 64'd0;
    end else if (state == S_WRITE) begin
      mem_we = 1'b1;
      mem_addr = {slot_tbl, slot_idx};
    end
  end

  assign cfg.ready = (state == S_IDLE);
  assign req.ready = (state == S_IDLE);
  assign rsp.valid = (state == S_DONE);
  assign rsp.status = res.status;
  assign rsp.phys_addr = res.phys_addr;
  assign rsp.tlb_invalidate = res.tlb_invalidate;
  assign rsp.tlb_page = res.tlb_page;

  // Sequence the walk
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      next_free <= '0;
      pool_base <= '0;
      link_pending <= 1'b0;
      create_mode <= 1'b0;
    end else begin
      unique case (state)
        S_IDLE: begin
          if (cfg.valid) begin
            pool_base <= cfg.data;
          end
          if (req.valid) begin
            cur <= '{cmd: req.cmd, root_addr: req.root_addr, va: req.va, pa: req.pa,
                     flags: req.flags};
            res <= '0;
            lv <= 2'd0;
            link_pending <= 1'b0;
            create_mode <= 1'b0;
            state <= S_CHECK;
          end
        end
        S_CHECK: begin
          if (cur.cmd == flptw_pkg::CMD_CREATE) begin
            if (next_free >= CW'(POOL_TABLES)) begin
              res.status <= flptw_pkg::ST_NO_POOL;
              state <= S_DONE;
            end else begin
              new_tbl <= next_free[TW-1:0];
              res.phys_addr <= tbl_addr(pool_base, next_free);
              next_free <= next_free + 1'b1;
              clr_idx <= '0;
              create_mode <= 1'b1;
              state <= S_CLEAR;
            end
          end else if (!chk_ok) begin
            res.status <= flptw_pkg::ST_BAD_ADDR;
            state <= S_DONE;
          end else begin
            tbl <= chk_tbl;
            state <= S_READ;
          end
        end
        S_READ: begin
          state <= S_EVAL;
        end
        S_EVAL: begin
          slot_tbl <= tbl;
          slot_idx <= cur_idx;
          if (lv == 2'd3 || (e_valid && !e_table) ||
              (!e_valid && cur.cmd != flptw_pkg::CMD_MAP)) begin
            if (cur.cmd == flptw_pkg::CMD_MAP) begin
              wr_val <= page_desc;
              state <= S_WRITE;
            end else if (!e_valid) begin
              res.status <= flptw_pkg::ST_UNMAPPED;
              state <= S_DONE;
            end else if (cur.cmd == flptw_pkg::CMD_UNMAP) begin
              wr_val <= 64'd0;
              res.tlb_invalidate <= 1'b1;
              res.tlb_page <= cur.va[63:12];
              state <= S_WRITE;
            end else begin
              // OR the va offset into the whole descriptor address
              priority case (lv)
                2'd1: res.phys_addr <= {mem_rdata[47:12], 12'd0} | {18'd0, cur.va[29:0]};
                2'd2: res.phys_addr <= {mem_rdata[47:12], 12'd0} | {27'd0, cur.va[20:0]};
                default: res.phys_addr <= {mem_rdata[47:12], cur.va[11:0]};
              endcase
              state <= S_DONE;
            end
          end else if (!e_valid) begin
            if (next_free >= CW'(POOL_TABLES)) begin
              res.status <= flptw_pkg::ST_NO_POOL;
              state <= S_DONE;
            end else begin
              new_tbl <= next_free[TW-1:0];
              wr_val <= {16'd0, tbl_addr(pool_base, next_free)} | flptw_pkg::D_VALID |
                        flptw_pkg::D_TABLE;
              next_free <= next_free + 1'b1;
              clr_idx <= '0;
              link_pending <= 1'b1;
              state <= S_CLEAR;
            end
          end else if (!chk_ok) begin
            res.status <= flptw_pkg::ST_BAD_ADDR;
            state <= S_DONE;
          end else begin
            tbl <= chk_tbl;
            lv <= lv + 2'd1;
            state <= S_READ;
          end
        end
        S_CLEAR: begin
          clr_idx <= clr_idx + 1'b1;
          if (clr_idx == '1) begin
            state <= create_mode ? S_DONE : S_WRITE;
          end
        end
        S_WRITE: begin
          if (link_pending) begin
            link_pending <= 1'b0;
            tbl <= new_tbl;
            lv <= lv + 2'd1;
            state <= S_READ;
          end else begin
            state <= S_DONE;
          end
        end
        S_DONE: begin
          if (rsp.ready) begin
            state <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  `FLPT_ASSERT_IMP(a_pool_bound, clk, rst, 1'b1, next_free <= CW'(POOL_TABLES), "pool overrun")
  `FLPT_ASSERT_IMP(a_inv_ok, clk, rst, rsp.valid && rsp.tlb_invalidate, rsp.status == flptw_pkg::ST_OK, "invalidate on error")
  `FLPT_ASSERT_NEXT(a_hold, clk, rst, rsp.valid && !rsp.ready, rsp.valid && $stable(rsp.phys_addr), "result dropped")
endmodule

// ===== sv/flptw_mem.sv =====
// Synchronous table store, one read/write port, registered read data.
module flptw_mem #(
  parameter int AW = 13
) (
  input  logic          clk,
  input  logic          we,
  input  logic [AW-1:0] addr,
  input  logic [63:0]   wdata,
  output logic [63:0]   rdata
);
  logic [63:0] mem [2**AW];

  // Write or read the addressed entry
  always_ff @(posedge clk) begin
    if (we) begin
      mem[addr] <= wdata;
    end
    rdata <= mem[addr];
  end
endmodule

// ===== test/four_level_page_table_walker_checker.sv =====
// Checker for the page table walker: tracks table state, predicts and compares responses.
`timescale 1ns / 100ps
module four_level_page_table_walker_checker #(
  parameter int POOL = 16
) (
  input  logic        clk,
  input  logic        rst,
  flptw_cfg_if        cfg,
  flptw_req_if        req,
  flptw_rsp_if        rsp,
  output int          errors,
  output int          pending
);
  localparam int ENTRIES = 512;

  logic [63:0] pt_mem [0:POOL*ENTRIES-1];
  int unsigned tables_used;
  logic [47:0] pool_addr;
  flptw_pkg::rsp_t expected_rsp [$];

  // Address of pool table n, wrapping at 48 bits.
  function automatic logic [47:0] pool_table_addr(int unsigned n);
    return pool_addr + (48'(n) << 12);
  endfunction

  // Map an address to an allocated table number.
  function automatic bit addr_to_tbl(logic [47:0] a, output int unsigned n);
    logic [47:0] off;
    off = a - pool_addr;
    n = 0;
    if (off[11:0] != 12'd0) return 0;
    if ((off >> 12) >= 48'(tables_used)) return 0;
    n = int'(off >> 12);
    return 1;
  endfunction

  // Hand out and clear the next free table.
  function automatic bit alloc_tbl(output int unsigned n);
    n = 0;
    if (tables_used >= POOL) return 0;
    n = tables_used;
    tables_used++;
    for (int i = 0; i < ENTRIES; i++) pt_mem[n*ENTRIES+i] = 64'd0;
    return 1;
  endfunction

  // Descend from a root table; give the final slot and level.
  function automatic logic [1:0] descend(int unsigned root, logic [63:0] va, bit grow,
                                         output int unsigned slot, output int unsigned lvl);
    int unsigned t, s, nt;
    logic [63:0] e;
    t = root;
    slot = 0;
    lvl = 0;
    for (int unsigned lv = 0; lv < 4; lv++) begin
      s = t*ENTRIES + int'((va >> (39 - 9*lv)) & 64'h1FF);
      e = pt_mem[s];
      if (lv == 3 || (e[0] && !e[1]) || (!e[0] && !grow)) begin
        slot = s;
        lvl = lv;
        return flptw_pkg::ST_OK;
      end
      if (!e[0]) begin
        if (!alloc_tbl(nt)) return flptw_pkg::ST_NO_POOL;
        pt_mem[s] = ({16'd0, pool_table_addr(nt)} & flptw_pkg::DESC_ADDR_MASK) |
                    flptw_pkg::D_VALID | flptw_pkg::D_TABLE;
        t = nt;
      end else if (!addr_to_tbl(e[47:0] & flptw_pkg::DESC_ADDR_MASK[47:0], t)) begin
        return flptw_pkg::ST_BAD_ADDR;
      end
    end
    return flptw_pkg::ST_BAD_ADDR;
  endfunction

  // Apply one command to the table state and return its response.
  function automatic flptw_pkg::rsp_t walk_command(flptw_pkg::req_t r);
    flptw_pkg::rsp_t o;
    int unsigned root, slot, lvl, nt;
    logic [63:0] vpage, d, e, pbase;
    logic [1:0] st;
    o = '0;
    if (r.cmd == flptw_pkg::CMD_CREATE) begin
      if (alloc_tbl(nt)) o.phys_addr = pool_table_addr(nt);
      else o.status = flptw_pkg::ST_NO_POOL;
    end else if (!addr_to_tbl(r.root_addr, root)) begin
      o.status = flptw_pkg::ST_BAD_ADDR;
    end else if (r.cmd == flptw_pkg::CMD_MAP) begin
      vpage = r.va & ~64'hFFF;
      st = descend(root, vpage, 1, slot, lvl);
      if (st != flptw_pkg::ST_OK) begin
        o.status = st;
      end else begin
        d = ({16'd0, r.pa} & flptw_pkg::DESC_ADDR_MASK) | flptw_pkg::D_VALID |
            flptw_pkg::D_TABLE | flptw_pkg::D_AF | flptw_pkg::D_SH_IS |
            flptw_pkg::D_ATTR_NORMAL | r.flags;
        if (vpage >= flptw_pkg::KERNEL_VA_BASE) d = d | flptw_pkg::D_UXN | flptw_pkg::D_PXN;
        pt_mem[slot] = d;
      end
    end else begin
      st = descend(root, r.va, 0, slot, lvl);
      e = pt_mem[slot];
      if (st != flptw_pkg::ST_OK) begin
        o.status = st;
      end else if (!e[0]) begin
        o.status = flptw_pkg::ST_UNMAPPED;
      end else if (r.cmd == flptw_pkg::CMD_UNMAP) begin
        pt_mem[slot] = 64'd0;
        o.tlb_invalidate = 1'b1;
        o.tlb_page = r.va[63:12];
      end else begin
        pbase = e & flptw_pkg::DESC_ADDR_MASK;
        if (lvl == 1) o.phys_addr = 48'(pbase | (r.va & 64'h3FFFFFFF));
        else if (lvl == 2) o.phys_addr = 48'(pbase | (r.va & 64'h1FFFFF));
        else o.phys_addr = 48'(pbase | (r.va & 64'hFFF));
      end
    end
    return o;
  endfunction

  // Track configuration and commands, then check each response transaction.
  always @(posedge clk) begin
    flptw_pkg::req_t r;
    flptw_pkg::rsp_t want;
    if (rst) begin
      errors = 0;
      tables_used = 0;
      pool_addr = '0;
      expected_rsp.delete();
    end else begin
      if (cfg.valid && cfg.ready) pool_addr = cfg.data & 48'hFFFF_FFFF_F000;
      if (req.valid && req.ready) begin
        r.cmd = req.cmd;
        r.root_addr = req.root_addr;
        r.va = req.va;
        r.pa = req.pa;
        r.flags = req.flags;
        expected_rsp.push_back(walk_command(r));
      end
      if (rsp.valid && rsp.ready) begin
        if (expected_rsp.size() == 0) begin
          $error("response transaction with no command outstanding");
          errors++;
        end else begin
          want = expected_rsp.pop_front();
          if (rsp.status !== want.status) begin
            $error("status: expected %0d, got %0d", want.status, rsp.status);
            errors++;
          end
          if (rsp.phys_addr !== want.phys_addr) begin
            $error("phys_addr: expected %h, got %h", want.phys_addr, rsp.phys_addr);
            errors++;
          end
          if (rsp.tlb_invalidate !== want.tlb_invalidate) begin
            $error("tlb_invalidate: expected %0d, got %0d", want.tlb_invalidate,
                   rsp.tlb_invalidate);
            errors++;
          end
          if (rsp.tlb_page !== want.tlb_page) begin
            $error("tlb_page: expected %h, got %h", want.tlb_page, rsp.tlb_page);
            errors++;
          end
        end
      end
    end
    pending <= expected_rsp.size();
  end
endmodule

// ===== test/four_level_page_table_walker_test.sv =====
// Testbench top for the page table walker: clock, reset, stimulus and verdict.
`timescale 1ns / 100ps
module four_level_page_table_walker_test;
  localparam int POOL = 16;
  localparam int CYCLE_LIMIT = 2000000;
  localparam int PHASE_ITEMS = 470;

  logic clk = 0;
  logic rst = 1;
  int   errors, pending;
  int   cycles = 0;
  int   burst_left = 0;
  logic [47:0] cur_base = '0;

  flptw_cfg_if cfg_ch ();
  flptw_req_if req_ch ();
  flptw_rsp_if rsp_ch ();

  four_level_page_table_walker #(.POOL_TABLES(POOL)) dut (
    .clk(clk), .rst(rst), .cfg(cfg_ch), .req(req_ch), .rsp(rsp_ch)
  );

  four_level_page_table_walker_checker #(.POOL(POOL)) chk (
    .clk(clk), .rst(rst), .cfg(cfg_ch), .req(req_ch), .rsp(rsp_ch),
    .errors(errors), .pending(pending)
  );

  always begin
    #10 clk = 1;
    #10 clk = 0;
  end

  // Abort on a hung run.
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("DONE: errors detected");
      $finish;
    end
  end

  // Response stall pattern: alternate free-running and stalling stretches.
  int stall_mode = 0;
  int stall_count = 0;
  always @(posedge clk) begin
    if (rst) begin
      rsp_ch.ready <= 1'b0;
    end else begin
      if (stall_count == 0) begin
        stall_mode <= $urandom_range(0, 2);
        stall_count <= $urandom_range(50, 400);
      end else begin
        stall_count <= stall_count - 1;
      end
      case (stall_mode)
        0: rsp_ch.ready <= 1'b1;
        1: rsp_ch.ready <= ($urandom_range(0, 3) != 0);
        default: rsp_ch.ready <= ($urandom_range(0, 9) == 0);
      endcase
    end
  end

  // Drive one command transaction, then hold or gap per the burst plan.
  task automatic send(logic [1:0] cmd, logic [47:0] root, logic [63:0] va,
                      logic [47:0] pa, logic [63:0] flags);
    req_ch.valid <= 1'b1;
    req_ch.cmd <= cmd;
    req_ch.root_addr <= root;
    req_ch.va <= va;
    req_ch.pa <= pa;
    req_ch.flags <= flags;
    do @(posedge clk); while (!req_ch.ready);
    if (burst_left == 0) begin
      req_ch.valid <= 1'b0;
      repeat ($urandom_range(1, 12)) @(posedge clk);
      burst_left = $urandom_range(0, 24);
    end else begin
      burst_left--;
    end
  endtask

  // Drain outstanding responses, then write the pool base.
  task automatic set_pool(logic [47:0] v);
    req_ch.valid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (4) @(posedge clk);
    cfg_ch.valid <= 1'b1;
    cfg_ch.data <= v;
    do @(posedge clk); while (!cfg_ch.ready);
    cfg_ch.valid <= 1'b0;
    cur_base = v & 48'hFFFF_FFFF_F000;
  endtask

  function automatic logic [47:0] tbl(int n);
    return cur_base + (48'(n) << 12);
  endfunction

  // Mostly VAs on a small index grid so walks hit earlier mappings.
  function automatic logic [63:0] pick_va();
    logic [15:0] hi;
    logic [8:0]  l0, l1, l2, l3;
    case ($urandom_range(0, 9))
      0: return {$urandom, $urandom};
      1: hi = 16'($urandom);
      2, 3: hi = 16'hFFFF;
      default: hi = 16'h0000;
    endcase
    case ($urandom_range(0, 2))
      0: l0 = 9'd0;
      1: l0 = 9'd1;
      default: l0 = 9'h1FF;
    endcase
    l1 = $urandom_range(0, 1) ? 9'd0 : 9'd3;
    l2 = $urandom_range(0, 1) ? 9'd0 : 9'h1FF;
    l3 = 9'($urandom_range(0, 3));
    return {hi, l0, l1, l2, l3, 12'($urandom)};
  endfunction

  function automatic logic [47:0] pick_root();
    case ($urandom_range(0, 19))
      0, 1: return {16'($urandom), $urandom};
      2: return tbl($urandom_range(0, POOL - 1)) + 48'($urandom_range(1, 4095));
      3: return tbl($urandom_range(POOL, POOL + 4));
      default: return tbl($urandom_range(0, POOL - 1));
    endcase
  endfunction

  task automatic random_phase(int n);
    logic [1:0]  cmd;
    logic [47:0] pa;
    logic [63:0] flags;
    int          sel;
    for (int i = 0; i < n; i++) begin
      sel = $urandom_range(0, 99);
      if (sel < 2) cmd = flptw_pkg::CMD_CREATE;
      else if (sel < 37) cmd = flptw_pkg::CMD_MAP;
      else if (sel < 57) cmd = flptw_pkg::CMD_UNMAP;
      else cmd = flptw_pkg::CMD_TRANSLATE;
      pa = ($urandom_range(0, 5) == 0) ? tbl($urandom_range(0, POOL)) :
           {16'($urandom), $urandom};
      flags = ($urandom_range(0, 7) == 0) ? {$urandom, $urandom} : 64'd0;
      send(cmd, pick_root(), pick_va(), pa, flags);
    end
  endtask

  initial begin
    cfg_ch.valid = 1'b0;
    cfg_ch.data = '0;
    req_ch.valid = 1'b0;
    req_ch.cmd = flptw_pkg::CMD_TRANSLATE;
    req_ch.root_addr = '0;
    req_ch.va = '0;
    req_ch.pa = '0;
    req_ch.flags = '0;
    repeat (9) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Directed: create, map user and kernel pages, translate, unmap, bad roots.
    set_pool(48'h0000_1234_5000);
    send(flptw_pkg::CMD_CREATE, '0, '0, '0, '0);
    send(flptw_pkg::CMD_MAP, tbl(0), 64'h0000_0000_0000_0000, 48'hFFFF_FFFF_FFFF, 64'd0);
    send(flptw_pkg::CMD_MAP, tbl(0), 64'hFFFF_FFFF_FFFF_FFFF, 48'h0000_8000_0000, 64'd0);
    send(flptw_pkg::CMD_MAP, tbl(0), 64'h0000_0080_0000_1ABC, 48'h0000_0001_2345,
         {32'hFFFF_FFFF, 32'hFFFF_FFFF});
    send(flptw_pkg::CMD_TRANSLATE, tbl(0), 64'h0000_0000_0000_0FFF, '0, '0);
    send(flptw_pkg::CMD_TRANSLATE, tbl(0), 64'hFFFF_FFFF_FFFF_F123, '0, '0);
    send(flptw_pkg::CMD_TRANSLATE, tbl(0), 64'h0000_0080_0000_1000, '0, '0);
    send(flptw_pkg::CMD_TRANSLATE, tbl(0), 64'h0000_0000_0000_1000, '0, '0);
    send(flptw_pkg::CMD_TRANSLATE, tbl(0), 64'h0000_0100_0000_0000, '0, '0);
    send(flptw_pkg::CMD_UNMAP, tbl(0), 64'hFFFF_FFFF_FFFF_FFFF, '0, '0);
    send(flptw_pkg::CMD_TRANSLATE, tbl(0), 64'hFFFF_FFFF_FFFF_FFFF, '0, '0);
    send(flptw_pkg::CMD_UNMAP, tbl(0), 64'hFFFF_FFFF_FFFF_FFFF, '0, '0);
    send(flptw_pkg::CMD_TRANSLATE, 48'hFFFF_FFFF_FFFF, 64'd0, '0, '0);
    send(flptw_pkg::CMD_MAP, tbl(0) + 48'h8, 64'd0, '0, '0);
    send(flptw_pkg::CMD_UNMAP, tbl(POOL - 1), 64'd0, '0, '0);
    send(flptw_pkg::CMD_MAP, tbl(1), 64'h0000_0000_0040_0000, tbl(0), 64'd0);
    send(flptw_pkg::CMD_TRANSLATE, tbl(3), 64'h0000_0000_0040_0000, '0, '0);
    send(flptw_pkg::CMD_CREATE, '0, '0, '0, '0);
    send(flptw_pkg::CMD_MAP, tbl(2), 64'hFFFF_0000_0000_0000, 48'h0000_0000_5000, 64'd0);

    // Random phases across several pool base settings, extremes included.
    random_phase(PHASE_ITEMS);
    set_pool(48'h0);
    random_phase(PHASE_ITEMS);
    set_pool(48'hFFFF_FFFF_FFFF);
    random_phase(PHASE_ITEMS);
    set_pool(48'h0000_1234_5000);
    random_phase(PHASE_ITEMS);

    req_ch.valid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (20) @(posedge clk);
    if (errors == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end
endmodule
